// ----- src/udw_pkg.sv -----
// constants, range tables and the column-width lookup for utf8_display_width
// stand-alone package, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package udw_pkg;

    // configuration defaults and fixed field widths
    localparam int UDW_TOTAL_BITS = 20;
    localparam int CP_W           = 21;
    localparam int COLS_W         = 2;
    localparam int BAD_W          = 3;
    localparam int TOTAL_OUT_W    = 20;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 48;

    // lead byte classes
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } t_span;

    localparam int WIDE_N = 106;
    localparam int ZERO_N = 19;

    // double-width (wide and fullwidth) ranges
    localparam t_span WIDE_TAB [WIDE_N] = '{
        '{21'h01100,21'h0115F}, '{21'h0231A,21'h0231B}, '{21'h02329,21'h0232A},
        '{21'h023E9,21'h023EC}, '{21'h023F0,21'h023F0}, '{21'h023F3,21'h023F3},
        '{21'h025FD,21'h025FE}, '{21'h02614,21'h02615}, '{21'h02648,21'h02653},
        '{21'h0267F,21'h0267F}, '{21'h02693,21'h02693}, '{21'h026A1,21'h026A1},
        '{21'h026AA,21'h026AB}, '{21'h026BD,21'h026BE}, '{21'h026C4,21'h026C5},
        '{21'h026CE,21'h026CE}, '{21'h026D4,21'h026D4}, '{21'h026EA,21'h026EA},
        '{21'h026F2,21'h026F3}, '{21'h026F5,21'h026F5}, '{21'h026FA,21'h026FA},
        '{21'h026FD,21'h026FD}, '{21'h02705,21'h02705}, '{21'h0270A,21'h0270B},
        '{21'h02728,21'h02728}, '{21'h0274C,21'h0274C}, '{21'h0274E,21'h0274E},
        '{21'h02753,21'h02755}, '{21'h02757,21'h02757}, '{21'h02795,21'h02797},
        '{21'h027B0,21'h027B0}, '{21'h027BF,21'h027BF}, '{21'h02B1B,21'h02B1C},
        '{21'h02B50,21'h02B50}, '{21'h02B55,21'h02B55}, '{21'h02E80,21'h02E99},
        '{21'h02E9B,21'h02EF3}, '{21'h02F00,21'h02FD5}, '{21'h02FF0,21'h02FFB},
        '{21'h03000,21'h0303E}, '{21'h03041,21'h03096}, '{21'h03099,21'h030FF},
        '{21'h03105,21'h0312F}, '{21'h03131,21'h0318E}, '{21'h03190,21'h031E3},
        '{21'h031F0,21'h0321E}, '{21'h03220,21'h03247}, '{21'h03250,21'h04DBF},
        '{21'h04E00,21'h0A48C}, '{21'h0A490,21'h0A4C6}, '{21'h0A960,21'h0A97C},
        '{21'h0AC00,21'h0D7A3}, '{21'h0F900,21'h0FAFF}, '{21'h0FE10,21'h0FE19},
        '{21'h0FE30,21'h0FE52}, '{21'h0FE54,21'h0FE66}, '{21'h0FE68,21'h0FE6B},
        '{21'h0FF01,21'h0FF60}, '{21'h0FFE0,21'h0FFE6}, '{21'h16FE0,21'h16FE4},
        '{21'h17000,21'h187F7}, '{21'h18800,21'h18CD5}, '{21'h1B000,21'h1B2FB},
        '{21'h1F004,21'h1F004}, '{21'h1F0CF,21'h1F0CF}, '{21'h1F18E,21'h1F18E},
        '{21'h1F191,21'h1F19A}, '{21'h1F200,21'h1F320}, '{21'h1F32D,21'h1F335},
        '{21'h1F337,21'h1F37C}, '{21'h1F37E,21'h1F393}, '{21'h1F3A0,21'h1F3CA},
        '{21'h1F3CF,21'h1F3D3}, '{21'h1F3E0,21'h1F3F0}, '{21'h1F3F4,21'h1F3F4},
        '{21'h1F3F8,21'h1F43E}, '{21'h1F440,21'h1F440}, '{21'h1F442,21'h1F4FC},
        '{21'h1F4FF,21'h1F53D}, '{21'h1F54B,21'h1F54E}, '{21'h1F550,21'h1F567},
        '{21'h1F57A,21'h1F57A}, '{21'h1F595,21'h1F596}, '{21'h1F5A4,21'h1F5A4},
        '{21'h1F5FB,21'h1F64F}, '{21'h1F680,21'h1F6C5}, '{21'h1F6CC,21'h1F6CC},
        '{21'h1F6D0,21'h1F6D2}, '{21'h1F6D5,21'h1F6D7}, '{21'h1F6EB,21'h1F6EC},
        '{21'h1F6F4,21'h1F6FC}, '{21'h1F7E0,21'h1F7EB}, '{21'h1F90C,21'h1F93A},
        '{21'h1F93C,21'h1F945}, '{21'h1F947,21'h1F978}, '{21'h1F97A,21'h1F9CB},
        '{21'h1F9CD,21'h1F9FF}, '{21'h1FA70,21'h1FA74}, '{21'h1FA78,21'h1FA7A},
        '{21'h1FA80,21'h1FA86}, '{21'h1FA90,21'h1FAA8}, '{21'h1FAB0,21'h1FAB6},
        '{21'h1FAC0,21'h1FAC2}, '{21'h1FAD0,21'h1FAD6}, '{21'h20000,21'h2FFFD},
        '{21'h30000,21'h3FFFD}
    };

    // zero-width (combining, format) ranges
    localparam t_span ZERO_TAB [ZERO_N] = '{
        '{21'h00300,21'h0036F}, '{21'h00483,21'h00489}, '{21'h00591,21'h005BD},
        '{21'h00610,21'h0061A}, '{21'h0064B,21'h0065F}, '{21'h00670,21'h00670},
        '{21'h006D6,21'h006DC}, '{21'h00E31,21'h00E31}, '{21'h00E34,21'h00E3A},
        '{21'h00EB1,21'h00EB1}, '{21'h0200B,21'h0200F}, '{21'h02028,21'h0202E},
        '{21'h02060,21'h02064}, '{21'h020D0,21'h020F0}, '{21'h0FE00,21'h0FE0F},
        '{21'h0FE20,21'h0FE2F}, '{21'h0FEFF,21'h0FEFF}, '{21'h1F3FB,21'h1F3FF},
        '{21'hE0100,21'hE01EF}
    };

    // terminal columns of one code point: 0, 1 or 2
    function automatic logic [COLS_W-1:0] columns_of(input logic [CP_W-1:0] v);
        logic ctrl;
        logic zero_hit;
        logic wide_hit;
        ctrl     = (v < CP_W'('h20)) || ((v >= CP_W'('h7F)) && (v < CP_W'('hA0)));
        zero_hit = 1'b0;
        wide_hit = 1'b0;
        for (int i = 0; i < ZERO_N; i++) begin
            if ((v >= ZERO_TAB[i].lo) && (v <= ZERO_TAB[i].hi)) zero_hit = 1'b1;
        end
        for (int i = 0; i < WIDE_N; i++) begin
            if ((v >= WIDE_TAB[i].lo) && (v <= WIDE_TAB[i].hi)) wide_hit = 1'b1;
        end
        if (ctrl || zero_hit) return COLS_W'(0);
        if (wide_hit) return COLS_W'(2);
        return COLS_W'(1);
    endfunction

    // classify a byte taken as a sequence lead
    function automatic t_lead lead_class(input logic [7:0] b);
        if (b[7] == 1'b0) return LEAD_ASCII;
        if (b[7:5] == 3'b110) return (b[4:1] == 4'b0000) ? LEAD_BAD : LEAD_TWO;
        if (b[7:4] == 4'b1110) return LEAD_THREE;
        if (b[7:3] == 5'b11110) return (b[2:0] > 3'd4) ? LEAD_BAD : LEAD_FOUR;
        return LEAD_BAD;
    endfunction

endpackage

`default_nettype wire

// ----- src/utf8_display_width.sv -----
// utf8_display_width: streaming utf-8 decoder with terminal column width
// depends on udw_pkg (tables, lead classes, column lookup)
//
// channel  | dir | tdata                                      | tuser     | tlast
// ---------+-----+--------------------------------------------+-----------+------------
// s_axis   | in  | [7:0] in_byte                              | -         | end_of_text
// m_axis   | out | [20:0] code_point, [22:21] cp_width,       | cp_valid  | text_done
//          |     | [25:23] bad_bytes, [45:26] total_width     |           |
//
// one byte per cycle sustained while the output is not stalled; a byte's result reaches the output
// through the input register, then decode and width lookup into the result register
// the decoder state and the running total advance as a byte leaves the input register
// i_rst_n (synchronous, active low) empties both registers and clears the decoder state
// an output stall holds the result; the input register still takes a byte if it is empty
`timescale 1ns / 1ps
`default_nettype none

module utf8_display_width #(
    parameter int TOTAL_BITS = udw_pkg::UDW_TOTAL_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // in_byte
    input  wire logic [udw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic                             s_axis_tlast,
    // code_point, cp_width, bad_bytes, total_width, zero pad
    output logic [udw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // cp_valid
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic                                  m_axis_tlast
);
    import udw_pkg::*;

    localparam int SUM_W = (TOTAL_BITS > TOTAL_OUT_W) ? TOTAL_BITS : TOTAL_OUT_W;
    localparam logic [TOTAL_BITS-1:0] CAP = {TOTAL_BITS{1'b1}};

    // input register
    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_last;

    // decoder state
    logic [1:0]          r_held;
    logic [1:0]          r_need;
    logic [CP_W-1:0]     r_part;
    logic [TOTAL_BITS-1:0] r_sum;

    // result register
    logic                       r_out_vld;
    logic                       r_cp_vld;
    logic [CP_W-1:0]            r_cp;
    logic [COLS_W-1:0]          r_cols;
    logic [BAD_W-1:0]           r_bad;
    logic [TOTAL_OUT_W-1:0]     r_total;
    logic                       r_done;

    // next values
    logic [1:0]            n_held;
    logic [1:0]            n_need;
    logic [CP_W-1:0]       n_part;
    logic [TOTAL_BITS-1:0] n_sum;
    logic                  n_cp_vld;
    logic [CP_W-1:0]       n_cp;
    logic [COLS_W-1:0]     n_cols;
    logic [BAD_W-1:0]      n_bad;

    logic                  advance;
    logic                  step;
    logic                  is_cont;
    logic [CP_W-1:0]       shifted;
    logic [TOTAL_BITS:0]   raw_sum;
    logic [SUM_W-1:0]      total_ext;

    // handshake: result register frees up when empty or taken
    assign advance       = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;

    // sequence decode
    assign is_cont = (r_held != 2'd0) && (r_byte[7:6] == 2'b10);
    assign shifted = {r_part[CP_W-7:0], r_byte[5:0]};

    always_comb begin
        n_held   = r_held;
        n_need   = r_need;
        n_part   = r_part;
        n_cp_vld = 1'b0;
        n_cp     = '0;
        n_bad    = '0;
        if (is_cont) begin
            n_part = shifted;
            n_need = r_need - 2'd1;
            n_held = r_held + 2'd1;
            if (r_need == 2'd1) begin
                n_cp_vld = 1'b1;
                n_cp     = shifted;
                n_held   = 2'd0;
                n_part   = '0;
            end
        end else begin
            // a broken sequence rejects every held byte
            if (r_held != 2'd0) begin
                n_bad  = BAD_W'(r_held);
                n_held = 2'd0;
                n_need = 2'd0;
                n_part = '0;
            end
            case (lead_class(r_byte))
                LEAD_ASCII: begin
                    n_cp_vld = 1'b1;
                    n_cp     = CP_W'(r_byte);
                end
                LEAD_TWO: begin
                    n_need = 2'd1;
                    n_part = CP_W'(r_byte[4:0]);
                    n_held = 2'd1;
                end
                LEAD_THREE: begin
                    n_need = 2'd2;
                    n_part = CP_W'(r_byte[3:0]);
                    n_held = 2'd1;
                end
                LEAD_FOUR: begin
                    n_need = 2'd3;
                    n_part = CP_W'(r_byte[2:0]);
                    n_held = 2'd1;
                end
                default: begin
                    n_bad = n_bad + BAD_W'(1);
                end
            endcase
        end
        // end of text flushes whatever is still held
        if (r_last) begin
            n_bad  = n_bad + BAD_W'(n_held);
            n_held = 2'd0;
            n_need = 2'd0;
            n_part = '0;
        end
    end

    // column width and saturating total
    assign n_cols  = n_cp_vld ? columns_of(n_cp) : COLS_W'(0);
    assign raw_sum = (TOTAL_BITS+1)'(r_sum) + (TOTAL_BITS+1)'(n_bad)
                   + (TOTAL_BITS+1)'(n_cols);
    assign n_sum   = raw_sum[TOTAL_BITS] ? CAP
                   : ((raw_sum[TOTAL_BITS-1:0] > CAP) ? CAP : raw_sum[TOTAL_BITS-1:0]);
    assign total_ext = SUM_W'(n_sum);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    // decoder state and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
            r_need <= 2'd0;
            r_part <= '0;
            r_sum  <= '0;
        end else if (step) begin
            r_held <= n_held;
            r_need <= n_need;
            r_part <= n_part;
            r_sum  <= r_last ? '0 : n_sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
        if (step) begin
            r_cp_vld <= n_cp_vld;
            r_cp     <= n_cp;
            r_cols   <= n_cols;
            r_bad    <= n_bad;
            r_total  <= total_ext[TOTAL_OUT_W-1:0];
            r_done   <= r_last;
        end
    end

    // output transfer
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_cp_vld;
    assign m_axis_tlast  = r_done;
    assign m_axis_tdata  = {2'b00, r_total, r_bad, r_cols, r_cp};

    // held bytes and pending continuations go together
    a_held_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == 2'd0) == (r_need == 2'd0))
        else $error("held count and continuation count disagree");

    // nothing gathered when no sequence is open
    a_idle_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == 2'd0) |-> (r_part == '0))
        else $error("partial value left over with no open sequence");

    // no code point means no value and no width
    a_no_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[22:0] == '0))
        else $error("value or width reported without a code point");

    // at most four bytes rejected per transfer
    a_bad_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:23] <= 3'd4))
        else $error("rejected byte count out of range");

    // end of text leaves the decoder empty and the total cleared
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_last) |=> ((r_held == 2'd0) && (r_sum == '0)))
        else $error("end of text did not flush the decoder");

endmodule

`default_nettype wire
